// ----- sv/fbm_pkg.sv -----
// Shared types and constants of the flow bandwidth meter.
// Holds the request and response row structs, command codes and register indexes.
// No dependencies.
package fbm_pkg;

   localparam int SNAP_DEPTH_DEF = 32;

   localparam int CMD_W       = 2;
   localparam int LEN_W       = 16;
   localparam int SEC_W       = 32;
   localparam int USEC_W      = 20;
   localparam int STAMP_W     = SEC_W + USEC_W;
   localparam int COUNT_W     = 64;
   localparam int ROW_W       = 32;
   localparam int INTERVAL_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Restoring divider: one quotient bit per step over the full count width.
   localparam int DIV_STEPS = COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EXPORT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START    = 2'd1;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [LEN_W-1:0]  packet_len;
      logic [SEC_W-1:0]  time_sec;
      logic [USEC_W-1:0] time_usec;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]  packets;
      logic [ROW_W-1:0]  bytes;
      logic [SEC_W-1:0]  first_sec;
      logic [USEC_W-1:0] first_usec;
      logic [SEC_W-1:0]  last_sec;
      logic [USEC_W-1:0] last_usec;
      logic [ROW_W-1:0]  pkt_rate;
      logic [ROW_W-1:0]  byte_rate;
      logic              overflow;
      logic              last_row;
   } rsp_row_type;

   typedef struct packed {
      logic [ROW_W-1:0]   packets;
      logic [ROW_W-1:0]   bytes;
      logic [STAMP_W-1:0] first_stamp;
      logic [STAMP_W-1:0] last_stamp;
      logic [ROW_W-1:0]   pkt_rate;
      logic [ROW_W-1:0]   byte_rate;
   } snap_entry_type;

endpackage

// ----- sv/flow_bandwidth_meter.sv -----
// Top level of the flow bandwidth meter: counters, snapshot store, shared divider.
// Depends on fbm_pkg for types, codes and widths.
//
// A transaction is taken when start is high and busy is low; result rows leave on
// rsp_row with a one-cycle rsp_valid strobe, and the receiver cannot stall them, so
// every row must be captured in the cycle it appears. Busy never rises for a packet
// command, so packets may follow back to back. A tick with a nonzero interval and
// room in the store, and an export of the live counters once a second has elapsed,
// both run one restoring divider, one quotient bit per cycle, first for the packet
// rate and then for the byte rate. A tick that stores nothing leaves busy low. An
// export of stored snapshots reads one row at a time through the single read port
// of the snapshot memory, whose read data is registered. The snapshot store needs
// no clearing after reset: only entries below the fill count are ever read.
module flow_bandwidth_meter #(
   parameter int SNAP_DEPTH = fbm_pkg::SNAP_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fbm_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   output fbm_pkg::rsp_row_type                rsp_row,
   input  logic                                csr_we,
   input  logic [fbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W  = $clog2(SNAP_DEPTH + 1);
   localparam int ADDR_W = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;

   localparam int SEC_W   = fbm_pkg::SEC_W;
   localparam int USEC_W  = fbm_pkg::USEC_W;
   localparam int STAMP_W = fbm_pkg::STAMP_W;
   localparam int COUNT_W = fbm_pkg::COUNT_W;
   localparam int ROW_W   = fbm_pkg::ROW_W;
   localparam int DCNT_W  = fbm_pkg::DIV_CNT_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV      = 3'd1;
   localparam logic [2:0] ST_STORE    = 3'd2;
   localparam logic [2:0] ST_LIVE     = 3'd3;
   localparam logic [2:0] ST_EXP_RD   = 3'd4;
   localparam logic [2:0] ST_EXP_EMIT = 3'd5;

   // sequencer
   logic [2:0] state_ff, state_in;
   logic       mode_export_ff, mode_export_in;   // divider result feeds a live row
   logic       phase_ff, phase_in;               // 0 packet rate, 1 byte rate

   // configuration and live counters
   logic [fbm_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [SEC_W-1:0]   period_ff, period_in;
   logic [COUNT_W-1:0] pkt_ff, pkt_in;
   logic [COUNT_W-1:0] byte_ff, byte_in;
   logic [STAMP_W-1:0] first_ff, first_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic               dropped_ff, dropped_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [SEC_W-1:0]   tsec_ff, tsec_in;

   // shared divider
   logic [COUNT_W-1:0] div_quo_ff, div_quo_in;
   logic [ROW_W-1:0]   div_rem_ff, div_rem_in;
   logic [ROW_W-1:0]   div_den_ff, div_den_in;
   logic [DCNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [ROW_W-1:0]   prate_ff, prate_in;
   logic [ROW_W-1:0]   brate_ff, brate_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   fbm_pkg::rsp_row_type  rsp_ff, rsp_in;

   // snapshot memory
   fbm_pkg::snap_entry_type snap_mem [SNAP_DEPTH];
   fbm_pkg::snap_entry_type rd_data_ff;
   fbm_pkg::snap_entry_type wr_data;

   logic               accept;
   logic [STAMP_W-1:0] stamp;
   logic [SEC_W-1:0]   elapsed;
   logic [ROW_W:0]     div_shift;
   logic [ROW_W:0]     div_diff;
   logic               div_ge;
   logic [COUNT_W-1:0] div_quo_next;
   logic               row_is_last;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign stamp  = {req_item.time_sec, req_item.time_usec};
   assign elapsed = req_item.time_sec - period_ff;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   assign div_shift    = {div_rem_ff, div_quo_ff[COUNT_W-1]};
   assign div_diff     = div_shift - {1'b0, div_den_ff};
   assign div_ge       = (div_shift >= {1'b0, div_den_ff});
   assign div_quo_next = {div_quo_ff[COUNT_W-2:0], div_ge};

   assign row_is_last = ((rd_cnt_ff + CNT_W'(1)) == used_ff);

   assign wr_data = '{packets:     pkt_ff[ROW_W-1:0],
                      bytes:       byte_ff[ROW_W-1:0],
                      first_stamp: first_ff,
                      last_stamp:  last_ff,
                      pkt_rate:    prate_ff,
                      byte_rate:   brate_ff};

   always_comb begin
      state_in       = state_ff;
      mode_export_in = mode_export_ff;
      phase_in       = phase_ff;
      interval_in    = interval_ff;
      period_in      = period_ff;
      pkt_in         = pkt_ff;
      byte_in        = byte_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      dropped_in     = dropped_ff;
      used_in        = used_ff;
      rd_cnt_in      = rd_cnt_ff;
      tsec_in        = tsec_ff;
      div_quo_in     = div_quo_ff;
      div_rem_in     = div_rem_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      prate_in       = prate_ff;
      brate_in       = brate_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               if (csr_index == fbm_pkg::REG_INTERVAL) begin
                  interval_in = csr_wdata[fbm_pkg::INTERVAL_W-1:0];
               end else if (csr_index == fbm_pkg::REG_START) begin
                  period_in = csr_wdata[SEC_W-1:0];
               end
            end
            if (accept) begin
               case (req_item.command)
                  fbm_pkg::CMD_PACKET: begin
                     if (pkt_ff == '0) begin
                        first_in = stamp;
                     end
                     last_in = stamp;
                     pkt_in  = pkt_ff + COUNT_W'(1);
                     byte_in = byte_ff + COUNT_W'(req_item.packet_len);
                  end
                  fbm_pkg::CMD_TICK: begin
                     if (interval_ff != '0 && used_ff < CNT_W'(SNAP_DEPTH)) begin
                        // keep the counters until the snapshot is written
                        div_den_in     = ROW_W'(interval_ff);
                        div_quo_in     = pkt_ff;
                        div_rem_in     = '0;
                        div_cnt_in     = '0;
                        phase_in       = 1'b0;
                        mode_export_in = 1'b0;
                        state_in       = ST_DIV;
                     end else begin
                        if (interval_ff != '0) begin
                           dropped_in = 1'b1;
                        end
                        pkt_in   = '0;
                        byte_in  = '0;
                        first_in = '0;
                        last_in  = '0;
                     end
                  end
                  fbm_pkg::CMD_EXPORT: begin
                     tsec_in = req_item.time_sec;
                     if (used_ff == '0) begin
                        if (elapsed != '0) begin
                           div_den_in     = elapsed;
                           div_quo_in     = pkt_ff;
                           div_rem_in     = '0;
                           div_cnt_in     = '0;
                           phase_in       = 1'b0;
                           mode_export_in = 1'b1;
                           state_in       = ST_DIV;
                        end else begin
                           prate_in = '0;
                           brate_in = '0;
                           state_in = ST_LIVE;
                        end
                     end else begin
                        rd_cnt_in = '0;
                        state_in  = ST_EXP_RD;
                     end
                  end
                  default: begin
                     // unused command code: drop it
                  end
               endcase
            end
         end
         ST_DIV: begin
            div_quo_in = div_quo_next;
            div_rem_in = div_ge ? div_diff[ROW_W-1:0] : div_shift[ROW_W-1:0];
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DCNT_W'(fbm_pkg::DIV_STEPS - 1)) begin
               if (!phase_ff) begin
                  prate_in   = div_quo_next[ROW_W-1:0];
                  phase_in   = 1'b1;
                  div_quo_in = byte_ff;
                  div_rem_in = '0;
               end else begin
                  brate_in = div_quo_next[ROW_W-1:0];
                  state_in = mode_export_ff ? ST_LIVE : ST_STORE;
               end
            end
         end
         ST_STORE: begin
            used_in  = used_ff + CNT_W'(1);
            pkt_in   = '0;
            byte_in  = '0;
            first_in = '0;
            last_in  = '0;
            state_in = ST_IDLE;
         end
         ST_LIVE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.packets     = pkt_ff[ROW_W-1:0];
            rsp_in.bytes       = byte_ff[ROW_W-1:0];
            rsp_in.first_sec   = first_ff[STAMP_W-1:USEC_W];
            rsp_in.first_usec  = first_ff[USEC_W-1:0];
            rsp_in.last_sec    = last_ff[STAMP_W-1:USEC_W];
            rsp_in.last_usec   = last_ff[USEC_W-1:0];
            rsp_in.pkt_rate    = prate_ff;
            rsp_in.byte_rate   = brate_ff;
            rsp_in.overflow    = dropped_ff;
            rsp_in.last_row    = 1'b1;
            pkt_in     = '0;
            byte_in    = '0;
            first_in   = '0;
            last_in    = '0;
            period_in  = tsec_ff;
            dropped_in = 1'b0;
            state_in   = ST_IDLE;
         end
         ST_EXP_RD: begin
            // memory read issued this cycle, data registered for the next
            state_in = ST_EXP_EMIT;
         end
         ST_EXP_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.packets     = rd_data_ff.packets;
            rsp_in.bytes       = rd_data_ff.bytes;
            rsp_in.first_sec   = rd_data_ff.first_stamp[STAMP_W-1:USEC_W];
            rsp_in.first_usec  = rd_data_ff.first_stamp[USEC_W-1:0];
            rsp_in.last_sec    = rd_data_ff.last_stamp[STAMP_W-1:USEC_W];
            rsp_in.last_usec   = rd_data_ff.last_stamp[USEC_W-1:0];
            rsp_in.pkt_rate    = rd_data_ff.pkt_rate;
            rsp_in.byte_rate   = rd_data_ff.byte_rate;
            rsp_in.overflow    = dropped_ff;
            rsp_in.last_row    = row_is_last;
            if (row_is_last) begin
               used_in    = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               state_in  = ST_EXP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= '0;
         period_ff    <= '0;
         pkt_ff       <= '0;
         byte_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         dropped_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         period_ff    <= period_in;
         pkt_ff       <= pkt_in;
         byte_ff      <= byte_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         dropped_ff   <= dropped_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      mode_export_ff <= mode_export_in;
      phase_ff       <= phase_in;
      rd_cnt_ff      <= rd_cnt_in;
      tsec_ff        <= tsec_in;
      div_quo_ff     <= div_quo_in;
      div_rem_ff     <= div_rem_in;
      div_den_ff     <= div_den_in;
      div_cnt_ff     <= div_cnt_in;
      prate_ff       <= prate_in;
      brate_ff       <= brate_in;
      rsp_ff         <= rsp_in;
   end

   // snapshot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         snap_mem[used_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (state_ff == ST_EXP_RD) begin
         rd_data_ff <= snap_mem[rd_cnt_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_ff;

   // fill count never passes the store depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(SNAP_DEPTH))
      else $error("snapshot fill count exceeds store depth");

   // the final row of an export always leaves the sequencer idle
   a_last_row_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row.last_row) |-> (state_ff == ST_IDLE))
      else $error("sequencer not idle after final row");

   // rows inside a snapshot stream are spaced by the memory read cycle
   a_row_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_row.last_row) |=> !rsp_valid)
      else $error("snapshot rows emitted back to back");

   // the divider never runs with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_den_ff != '0))
      else $error("divider running with zero divisor");

   // a store write only happens with room left
   a_store_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> (used_ff < CNT_W'(SNAP_DEPTH)))
      else $error("snapshot written into a full store");

endmodule
